FILE: rtl/mfti_pkg.sv
// ----------------------------------------------------------------------------
// mfti_pkg
// Shared constants, command/status types and the exp ROM builder for the
// fuzzy tip inference block.
// ----------------------------------------------------------------------------
package mfti_pkg;

  localparam int unsigned GridPointsDef = 301;
  localparam int unsigned GradeBitsDef  = 8;

  localparam int unsigned ScoreW   = 12;
  localparam int unsigned ScoreMax = 2560;
  localparam int unsigned TipW     = 13;
  localparam int unsigned TipScale = 7680;
  localparam int unsigned RomSize  = 128;
  localparam int unsigned RomIdxW  = 7;
  localparam int unsigned CfgIdxW  = 3;

  // output grid spans 0..30, triangles have half width 5
  localparam int unsigned GridRange = 30;
  localparam int unsigned TriHalf   = 5;
  localparam int unsigned TriCtr [3] = '{5, 15, 25};

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPoorCtr   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGoodCtr   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgExcCtr    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRanFull   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRanZero   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDelRise   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDelFull   = 3'd6;

  localparam logic [ScoreW-1:0] PoorCtrRst = 12'd0;
  localparam logic [ScoreW-1:0] GoodCtrRst = 12'd1280;
  localparam logic [ScoreW-1:0] ExcCtrRst  = 12'd2560;
  localparam logic [ScoreW-1:0] RanFullRst = 12'd256;
  localparam logic [ScoreW-1:0] RanZeroRst = 12'd768;
  localparam logic [ScoreW-1:0] DelRiseRst = 12'd1792;
  localparam logic [ScoreW-1:0] DelFullRst = 12'd2304;

  typedef enum logic [1:0] {
    DivRancid,
    DivDelicious,
    DivTip
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     fuzz;
    logic     div_start;
    div_sel_e div_sel;
    logic     latch_rancid;
    logic     latch_delicious;
    logic     grid_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic grid_busy;
    logic out_stall;
  } dp_status_t;

  typedef logic [15:0] exp_rom_t [RomSize];

  // shift-subtract quotient, used only while the table is built
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // rom[k] = one * exp(-k^2/1152), q28 series, reciprocal and four squarings
  function automatic exp_rom_t exp_rom_build(input int unsigned grade_bits);
    exp_rom_t        rom;
    longint unsigned y;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned inv;
    longint unsigned one;
    int unsigned     n;
    one = (64'd1 << grade_bits) - 64'd1;
    for (int unsigned k = 0; k < RomSize; k++) begin
      y    = (longint'(k * k) << 28) / 18432;
      sum  = 64'd1 << 28;
      term = 64'd1 << 28;
      n    = 1;
      while (n < 40 && term != 0) begin
        term = udiv64((term * y) >> 28, 64'(n));
        sum  = sum + term;
        n    = n + 1;
      end
      inv = udiv64(64'd1 << 56, sum);
      for (int unsigned s = 0; s < 4; s++) begin
        inv = (inv * inv + (64'd1 << 27)) >> 28;
      end
      rom[k] = 16'((inv * one + (64'd1 << 27)) >> 28);
    end
    return rom;
  endfunction

endpackage

FILE: rtl/mfti_div.sv
// ----------------------------------------------------------------------------
// mfti_div
// Restoring divider, one quotient bit per cycle; the quotient must fit QUO_W.
// ----------------------------------------------------------------------------
module mfti_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 24,
  parameter int unsigned QUO_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned DshW = DEN_W + QUO_W - 1;
  localparam int unsigned CmpW = (NUM_W > DshW) ? NUM_W : DshW;
  localparam int unsigned CntW = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [NUM_W-1:0] rem_q;
  logic [DshW-1:0]  dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [CmpW-1:0] rem_ext;
  logic [CmpW-1:0] dsh_ext;
  logic [CmpW-1:0] diff;
  logic            ge;

  assign rem_ext = CmpW'(rem_q);
  assign dsh_ext = CmpW'(dsh_q);
  assign diff    = rem_ext - dsh_ext;
  assign ge      = (rem_ext >= dsh_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(QUO_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[QUO_W-2:0], ge};
      if (ge) begin
        rem_q <= NUM_W'(diff);
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

FILE: rtl/mfti_datapath.sv
// ----------------------------------------------------------------------------
// mfti_datapath
// Config registers, fuzzifier, grid pipeline with accumulators, shared
// divider and output register.
// ----------------------------------------------------------------------------
module mfti_datapath
  import mfti_pkg::*;
#(
  parameter int unsigned GRID_POINTS = GridPointsDef,
  parameter int unsigned GRADE_BITS  = GradeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ScoreW-1:0]   cfg_data_i,
  input  logic [2*ScoreW-1:0] in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TipW-1:0]     tip_o,
  output logic                no_support_o
);

  localparam int unsigned N     = GRID_POINTS - 1;
  localparam int unsigned IW    = $clog2(GRID_POINTS);
  localparam int unsigned G     = GRADE_BITS;
  localparam int unsigned PW    = IW + 5;
  localparam int unsigned TNW   = G + IW + 3;
  localparam int unsigned Half  = TriHalf * N;
  localparam int unsigned HalfRnd = Half / 2;
  localparam longint unsigned Recip = (longint'(1) << TNW) / Half;
  localparam int unsigned S0W   = G + IW;
  localparam int unsigned S1W   = G + 2 * IW;
  localparam int unsigned DenW  = G + 2 * IW;
  localparam int unsigned NumW  = S1W + 14;
  localparam int unsigned QuoW  = (G > TipW) ? G : TipW;
  localparam int unsigned RampW = ScoreW + G + 1;
  localparam int unsigned AiW   = G + IW;

  localparam exp_rom_t ExpRom = exp_rom_build(GRADE_BITS);
  localparam logic [G-1:0] GOne = '1;

  // config registers
  logic [ScoreW-1:0] poor_q, good_q, exc_q, ran_full_q, ran_zero_q, del_rise_q, del_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poor_q     <= PoorCtrRst;
      good_q     <= GoodCtrRst;
      exc_q      <= ExcCtrRst;
      ran_full_q <= RanFullRst;
      ran_zero_q <= RanZeroRst;
      del_rise_q <= DelRiseRst;
      del_full_q <= DelFullRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPoorCtr: poor_q     <= cfg_data_i;
        CfgGoodCtr: good_q     <= cfg_data_i;
        CfgExcCtr:  exc_q      <= cfg_data_i;
        CfgRanFull: ran_full_q <= cfg_data_i;
        CfgRanZero: ran_zero_q <= cfg_data_i;
        CfgDelRise: del_rise_q <= cfg_data_i;
        CfgDelFull: del_full_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input capture with saturation
  logic [ScoreW-1:0] svc_q, food_q, svc_in, food_in;

  assign svc_in  = in_data_i[ScoreW-1:0];
  assign food_in = in_data_i[2*ScoreW-1:ScoreW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      svc_q  <= (svc_in > ScoreW'(ScoreMax)) ? ScoreW'(ScoreMax) : svc_in;
      food_q <= (food_in > ScoreW'(ScoreMax)) ? ScoreW'(ScoreMax) : food_in;
    end
  end

  function automatic logic [G-1:0] gauss(input logic [ScoreW-1:0] s,
                                         input logic [ScoreW-1:0] c);
    logic [ScoreW-1:0] d;
    logic [ScoreW:0]   ks;
    d  = (s >= c) ? s - c : c - s;
    ks = ({1'b0, d} + (ScoreW+1)'(8)) >> 4;
    if (ks < (ScoreW+1)'(RomSize)) begin
      return G'(ExpRom[ks[RomIdxW-1:0]]);
    end
    return '0;
  endfunction

  // fuzzification
  logic [G-1:0] g_poor_q, g_good_q, g_exc_q, rancid_q, delic_q;
  logic         ran_ramp_q, del_ramp_q;
  logic [G-1:0] r1_q, r2_q, r3_q;
  logic [QuoW-1:0] quo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fuzz) begin
      g_poor_q <= gauss(svc_q, poor_q);
      g_good_q <= gauss(svc_q, good_q);
      g_exc_q  <= gauss(svc_q, exc_q);
      ran_ramp_q <= 1'b0;
      if (food_q >= ran_zero_q) begin
        rancid_q <= '0;
      end else if (food_q < ran_full_q) begin
        rancid_q <= GOne;
      end else begin
        ran_ramp_q <= 1'b1;
      end
      del_ramp_q <= 1'b0;
      if (food_q >= del_full_q) begin
        delic_q <= GOne;
      end else if (food_q < del_rise_q) begin
        delic_q <= '0;
      end else begin
        del_ramp_q <= 1'b1;
      end
    end
    if (cmd_i.latch_rancid && ran_ramp_q) begin
      rancid_q <= quo[G-1:0];
    end
    if (cmd_i.latch_delicious && del_ramp_q) begin
      delic_q <= quo[G-1:0];
    end
    if (cmd_i.grid_start) begin
      r1_q <= (g_poor_q >= rancid_q) ? g_poor_q : rancid_q;
      r2_q <= g_good_q;
      r3_q <= (g_exc_q >= delic_q) ? g_exc_q : delic_q;
    end
  end

  // grid pipeline: tri numerator, reciprocal estimate, back-multiply,
  // correct and clip, weight by index, accumulate
  logic [IW-1:0]  idx_q;
  logic           run_q;
  logic [4:0]     pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pv_q  <= '0;
      idx_q <= '0;
    end else begin
      pv_q <= {pv_q[3:0], run_q};
      if (cmd_i.grid_start) begin
        run_q <= 1'b1;
        idx_q <= '0;
      end else if (run_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == IW'(N)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  logic [TNW-1:0] tnum_a_q [3];
  logic           in_a_q   [3];
  logic [IW-1:0]  idx_a_q, idx_b_q, idx_c_q, idx_d_q;
  logic [G-1:0]   est_b_q  [3];
  logic [TNW-1:0] tnum_b_q [3];
  logic           in_b_q   [3];
  logic [TNW-1:0] qh_c_q   [3];
  logic [G-1:0]   est_c_q  [3];
  logic [TNW-1:0] tnum_c_q [3];
  logic           in_c_q   [3];
  logic [G-1:0]   a_d_q, a_e_q;
  logic [AiW-1:0] ai_e_q;
  logic [S0W-1:0] s0_q;
  logic [S1W-1:0] s1_q;

  logic [PW-1:0]    pos;
  logic [PW-1:0]    tdist [3];
  logic [TNW-1:0]   tnum [3];
  logic             in_tri [3];
  logic [2*TNW-1:0] prod [3];
  logic [TNW-1:0]   rem [3];
  logic [G:0]       grd_w [3];
  logic [G-1:0]     grd [3];
  logic [G-1:0]     clip [3];
  logic [G-1:0]     rule [3];
  logic [G-1:0]     agg;

  assign rule[0] = r1_q;
  assign rule[1] = r2_q;
  assign rule[2] = r3_q;
  assign pos     = PW'(idx_q) * PW'(GridRange);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tdist[k]  = (pos >= PW'(TriCtr[k] * N)) ? pos - PW'(TriCtr[k] * N)
                                              : PW'(TriCtr[k] * N) - pos;
      in_tri[k] = (tdist[k] < PW'(Half));
      tnum[k]   = TNW'(GOne) * TNW'(PW'(Half) - tdist[k]) + TNW'(HalfRnd);
      prod[k]   = (2*TNW)'(tnum_a_q[k]) * (2*TNW)'(Recip);
      rem[k]    = tnum_c_q[k] - qh_c_q[k];
      grd_w[k]  = (rem[k] >= TNW'(Half)) ? {1'b0, est_c_q[k]} + 1'b1 : {1'b0, est_c_q[k]};
      grd[k]    = in_c_q[k] ? grd_w[k][G-1:0] : '0;
      clip[k]   = (rule[k] <= grd[k]) ? rule[k] : grd[k];
    end
    agg = clip[0];
    if (clip[1] > agg) agg = clip[1];
    if (clip[2] > agg) agg = clip[2];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      tnum_a_q[k] <= tnum[k];
      in_a_q[k]   <= in_tri[k];
      est_b_q[k]  <= prod[k][TNW +: G];
      tnum_b_q[k] <= tnum_a_q[k];
      in_b_q[k]   <= in_a_q[k];
      qh_c_q[k]   <= TNW'(est_b_q[k]) * TNW'(Half);
      est_c_q[k]  <= est_b_q[k];
      tnum_c_q[k] <= tnum_b_q[k];
      in_c_q[k]   <= in_b_q[k];
    end
    idx_a_q <= idx_q;
    idx_b_q <= idx_a_q;
    idx_c_q <= idx_b_q;
    a_d_q   <= agg;
    idx_d_q <= idx_c_q;
    a_e_q   <= a_d_q;
    ai_e_q  <= AiW'(a_d_q) * AiW'(idx_d_q);
    if (cmd_i.grid_start) begin
      s0_q <= '0;
      s1_q <= '0;
    end else if (pv_q[4]) begin
      s0_q <= s0_q + S0W'(a_e_q);
      s1_q <= s1_q + S1W'(ai_e_q);
    end
  end

  // divider operands
  logic [ScoreW-1:0] ran_dist, ran_span, del_dist, del_span;
  logic [DenW-1:0]   tip_den;
  logic [NumW-1:0]   div_num;
  logic [DenW-1:0]   div_den;

  assign ran_dist = ran_zero_q - food_q;
  assign ran_span = ran_zero_q - ran_full_q;
  assign del_dist = food_q - del_rise_q;
  assign del_span = del_full_q - del_rise_q;
  assign tip_den  = DenW'(s0_q) * DenW'(N);

  always_comb begin
    case (cmd_i.div_sel)
      DivRancid: begin
        div_num = NumW'(RampW'(ran_dist) * RampW'(GOne) + RampW'(ran_span >> 1));
        div_den = DenW'(ran_span);
      end
      DivDelicious: begin
        div_num = NumW'(RampW'(del_dist) * RampW'(GOne) + RampW'(del_span >> 1));
        div_den = DenW'(del_span);
      end
      DivTip: begin
        div_num = NumW'(s1_q) * NumW'(TipScale) + NumW'(tip_den >> 1);
        div_den = tip_den;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  logic div_done;

  mfti_div #(
    .NUM_W(NumW),
    .DEN_W(DenW),
    .QUO_W(QuoW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .done_o (div_done)
  );

  // output register
  logic            out_valid_q;
  logic [TipW-1:0] tip_q;
  logic            nosup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      nosup_q <= (s0_q == '0);
      tip_q   <= (s0_q == '0) ? '0 : quo[TipW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tip_o              = tip_q;
  assign no_support_o       = nosup_q;
  assign status_o.div_done  = div_done;
  assign status_o.grid_busy = run_q | (|pv_q);
  assign status_o.out_stall = out_valid_q & ~out_ready_i;

endmodule

FILE: rtl/mfti_ctrl.sv
// ----------------------------------------------------------------------------
// mfti_ctrl
// Sequencer: capture, fuzzify, two ramp divisions, grid pass, centroid
// division, output load.
// ----------------------------------------------------------------------------
module mfti_ctrl
  import mfti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StFuzz     = 4'd1;
  localparam logic [3:0] StRanGo    = 4'd2;
  localparam logic [3:0] StRanWait  = 4'd3;
  localparam logic [3:0] StDelGo    = 4'd4;
  localparam logic [3:0] StDelWait  = 4'd5;
  localparam logic [3:0] StGridGo   = 4'd6;
  localparam logic [3:0] StGridWait = 4'd7;
  localparam logic [3:0] StFinGo    = 4'd8;
  localparam logic [3:0] StFinWait  = 4'd9;
  localparam logic [3:0] StOut      = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.div_sel = DivTip;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StFuzz;
        end
      end
      StFuzz: begin
        cmd_o.fuzz = 1'b1;
        state_d    = StRanGo;
      end
      StRanGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivRancid;
        state_d         = StRanWait;
      end
      StRanWait: begin
        if (status_i.div_done) begin
          cmd_o.latch_rancid = 1'b1;
          state_d            = StDelGo;
        end
      end
      StDelGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivDelicious;
        state_d         = StDelWait;
      end
      StDelWait: begin
        if (status_i.div_done) begin
          cmd_o.latch_delicious = 1'b1;
          state_d               = StGridGo;
        end
      end
      StGridGo: begin
        cmd_o.grid_start = 1'b1;
        state_d          = StGridWait;
      end
      StGridWait: begin
        if (!status_i.grid_busy) begin
          state_d = StFinGo;
        end
      end
      StFinGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = StFinWait;
      end
      StFinWait: begin
        if (status_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        // wait for the previous result to leave the output register
        if (!status_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/mamdani_fuzzy_tip_inference_top.sv
// ----------------------------------------------------------------------------
// mamdani_fuzzy_tip_inference_top
// Mamdani fuzzy tip inference with centroid defuzzification.
//
//   channel   direction  payload
//   s_axis    in         tdata: service_level [11:0], food_quality [23:12]
//   m_axis    out        tdata: tip_amount [12:0]; tuser: no_support [0]
//   cfg       in         write enable, register index, 12-bit data
//
// One request at a time: two ramp divisions and the centroid division on the
// shared divider, plus one grid point per cycle through a 6-stage pipeline.
// A new request is taken while the last result still waits on m_axis.
// Reset is asynchronous active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mamdani_fuzzy_tip_inference_top
  import mfti_pkg::*;
#(
  parameter int unsigned GRID_POINTS = GridPointsDef,
  parameter int unsigned GRADE_BITS  = GradeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*ScoreW-1:0] s_axis_tdata,   // service_level, food_quality
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // tip_amount, zero pad
  output logic [0:0]          m_axis_tuser,   // no_support
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ScoreW-1:0]   cfg_data_i
);

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [TipW-1:0] tip;
  logic            no_support;

  mfti_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mfti_datapath #(
    .GRID_POINTS(GRID_POINTS),
    .GRADE_BITS (GRADE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tip_o       (tip),
    .no_support_o(no_support)
  );

  assign m_axis_tdata = {{(16-TipW){1'b0}}, tip};
  assign m_axis_tuser = no_support;

endmodule
